### rtl/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

    // Fraction bits of the reported roots
    localparam int OUT_FRAC = 16;

    // Solution kind codes
    localparam logic [2:0] KIND_TWO      = 3'd0;
    localparam logic [2:0] KIND_DOUBLE   = 3'd1;
    localparam logic [2:0] KIND_NO_REAL  = 3'd2;
    localparam logic [2:0] KIND_LINEAR   = 3'd3;
    localparam logic [2:0] KIND_INFINITE = 3'd4;
    localparam logic [2:0] KIND_NONE     = 3'd5;

    // Command to the shared step unit
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } qrs_step_ctl_t;

    function automatic int max_int(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

### rtl/qrs_step_unit.sv
`timescale 1ns / 1ps

module qrs_step_unit #(
    parameter int COEF_WIDTH = 16,
    localparam int NW   = COEF_WIDTH + qrs_pkg::OUT_FRAC + 2,
    localparam int AW   = qrs_pkg::max_int(NW, 33),
    localparam int OW   = qrs_pkg::max_int(2 * COEF_WIDTH + 2, NW),
    localparam int DW   = COEF_WIDTH + 1,
    localparam int CNTW = $clog2(NW + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qrs_pkg::qrs_step_ctl_t ctl,
    input  logic [OW-1:0]        opnd_in,
    input  logic [DW-1:0]        den_in,
    input  logic [CNTW-1:0]      steps,
    output logic                 done,
    output logic [AW-1:0]        acc
);

    localparam int SW = COEF_WIDTH + 4;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            mode_reg, mode_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]   rem_reg, rem_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [OW-1:0]   opnd_reg, opnd_next;
    logic [DW-1:0]   den_reg, den_next;

    logic [SW-1:0]   sub_x;
    logic [SW-1:0]   sub_y;
    logic [SW:0]     sub_d;
    logic            sub_ge;
    logic [OW-1:0]   opnd_shift;

    // Select operands of the shared subtractor: root digit trial or quotient bit trial
    always_comb
    begin
        if (mode_reg)
        begin
            sub_x      = {rem_reg[SW-3:0], opnd_reg[OW-1 -: 2]};
            sub_y      = {acc_reg[SW-3:0], 2'b01};
            opnd_shift = opnd_reg << 2;
        end
        else
        begin
            sub_x      = {rem_reg[SW-2:0], opnd_reg[OW-1]};
            sub_y      = SW'(den_reg);
            opnd_shift = opnd_reg << 1;
        end
        sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
        sub_ge = ~sub_d[SW];
    end

    // Load on start, then advance one bit of result per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        opnd_next = opnd_reg;
        den_next  = den_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            mode_next = ctl.sqrt_mode;
            cnt_next  = steps;
            rem_next  = '0;
            acc_next  = '0;
            opnd_next = opnd_in;
            den_next  = den_in;
        end
        else if (busy_reg)
        begin
            rem_next  = sub_ge ? sub_d[SW-1:0] : sub_x;
            acc_next  = {acc_reg[AW-2:0], sub_ge};
            opnd_next = opnd_shift;
            cnt_next  = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

### rtl/quadratic_root_solver_core.sv
`timescale 1ns / 1ps

// Quadratic root solver: a*x^2 + b*x + c = 0 on signed fixed-point coefficients.
// Input channel (in_valid/in_ready) carries coef_a, coef_b, coef_c, all on one scale.
// Output channel (out_valid/out_ready) carries solution_kind, root_plus, root_minus
// (signed Q16.16, saturated) and root_saturated, one result item per input item.
// The work after accept depends on the solution kind: a square root and two long
// divisions for two real roots, a square root and one division for a double root, one
// division for a linear equation, and neither when a and b are zero or with no real root.
// The work is done by one shared subtract unit that runs the bit-serial square root
// (one root bit a cycle) and each long division (one quotient bit a cycle), in turn.
// One item is worked on at a time; in_ready is high only while the sequencer is idle,
// so a new item is not accepted until the last one has left the sequencer.
// A finished result sits in an output register; the next item is accepted and worked
// on while it waits, and the sequencer holds its finished item until the register
// is taken when out_ready stays low.
// Reset clears the sequencer and out_valid; the block is then idle and ready.

module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COEF_WIDTH-1:0] coef_a,
    input  logic signed [COEF_WIDTH-1:0] coef_b,
    input  logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   solution_kind,
    output logic signed [31:0]           root_plus,
    output logic signed [31:0]           root_minus,
    output logic                         root_saturated
);

    localparam int W    = COEF_WIDTH;
    localparam int NW   = W + qrs_pkg::OUT_FRAC + 2;
    localparam int AW   = qrs_pkg::max_int(NW, 33);
    localparam int OW   = qrs_pkg::max_int(2 * W + 2, NW);
    localparam int DW   = W + 1;
    localparam int CNTW = $clog2(NW + 1);
    localparam int DSW  = 2 * W + 3;
    localparam int RNW  = W + 3;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MULB    = 4'd1;
    localparam logic [3:0] S_MULAC   = 4'd2;
    localparam logic [3:0] S_DISC    = 4'd3;
    localparam logic [3:0] S_CLASS   = 4'd4;
    localparam logic [3:0] S_SQRT    = 4'd5;
    localparam logic [3:0] S_DIVP_GO = 4'd6;
    localparam logic [3:0] S_DIVP    = 4'd7;
    localparam logic [3:0] S_DIVM_GO = 4'd8;
    localparam logic [3:0] S_DIVM    = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    logic signed [W-1:0]   a_reg, a_next;
    logic signed [W-1:0]   b_reg, b_next;
    logic signed [W-1:0]   c_reg, c_next;
    logic signed [DSW-1:0] disc_reg, disc_next;
    logic [2*W-1:0]        prod_reg, prod_next;
    logic [W:0]            sq_reg, sq_next;
    logic [2:0]            kind_reg, kind_next;
    logic [31:0]           rp_reg, rp_next;
    logic [31:0]           rm_reg, rm_next;
    logic                  sat_reg, sat_next;
    logic                  neg_reg, neg_next;

    logic [2:0]            out_kind_reg, out_kind_next;
    logic [31:0]           out_rp_reg, out_rp_next;
    logic [31:0]           out_rm_reg, out_rm_next;
    logic                  out_sat_reg, out_sat_next;

    logic [W-1:0]          mag_a;
    logic [W-1:0]          mag_b;
    logic [W-1:0]          mag_c;
    logic [W-1:0]          mul_x;
    logic [W-1:0]          mul_y;
    logic [2*W-1:0]        mul_p;
    logic [DSW-1:0]        prod4;

    logic signed [RNW-1:0] b_ext;
    logic signed [RNW-1:0] sq_ext;
    logic signed [RNW-1:0] num_p;
    logic signed [RNW-1:0] num_m;
    logic signed [RNW-1:0] num_sel;
    logic [RNW-1:0]        num_mag;

    qrs_pkg::qrs_step_ctl_t step_ctl;
    logic [OW-1:0]         step_opnd;
    logic [DW-1:0]         step_den;
    logic [CNTW-1:0]       step_cnt;
    logic                  step_done;
    logic [AW-1:0]         step_acc;

    logic                  q_pos_over;
    logic                  q_neg_over;
    logic [31:0]           q_val;
    logic                  q_sat;

    // Coefficient magnitudes
    assign mag_a = a_reg[W-1] ? W'(-a_reg) : W'(a_reg);
    assign mag_b = b_reg[W-1] ? W'(-b_reg) : W'(b_reg);
    assign mag_c = c_reg[W-1] ? W'(-c_reg) : W'(c_reg);

    // Shared multiplier: b*b first, then a*c
    assign mul_x = (state_reg == S_MULB) ? mag_b : mag_a;
    assign mul_y = (state_reg == S_MULB) ? mag_b : mag_c;
    assign mul_p = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
    assign prod4 = {1'b0, prod_reg, 2'b00};

    // Root numerators -b + sqrt(D) and -b - sqrt(D)
    assign b_ext   = {{3{b_reg[W-1]}}, b_reg};
    assign sq_ext  = {2'b00, sq_reg};
    assign num_p   = sq_ext - b_ext;
    assign num_m   = -sq_ext - b_ext;
    assign num_sel = (state_reg == S_DIVP_GO) ? num_p : num_m;
    assign num_mag = num_sel[RNW-1] ? RNW'(-num_sel) : RNW'(num_sel);

    // Clip the quotient to 32-bit signed and apply the sign
    always_comb
    begin
        q_pos_over = step_acc > AW'(33'h0_7FFF_FFFF);
        q_neg_over = step_acc > AW'(33'h0_8000_0000);
        if (neg_reg)
        begin
            q_sat = q_neg_over;
            q_val = q_neg_over ? 32'h8000_0000 : (32'd0 - step_acc[31:0]);
        end
        else
        begin
            q_sat = q_pos_over;
            q_val = q_pos_over ? 32'h7FFF_FFFF : step_acc[31:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        disc_next      = disc_reg;
        prod_next      = prod_reg;
        sq_next        = sq_reg;
        kind_next      = kind_reg;
        rp_next        = rp_reg;
        rm_next        = rm_reg;
        sat_next       = sat_reg;
        neg_next       = neg_reg;
        out_kind_next  = out_kind_reg;
        out_rp_next    = out_rp_reg;
        out_rm_next    = out_rm_reg;
        out_sat_next   = out_sat_reg;
        step_ctl       = '0;
        step_opnd      = '0;
        step_den       = '0;
        step_cnt       = CNTW'(NW);

        // Drop the output item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = coef_a;
                    b_next     = coef_b;
                    c_next     = coef_c;
                    state_next = S_MULB;
                end
            end
            S_MULB:
            begin
                rp_next  = '0;
                rm_next  = '0;
                sat_next = 1'b0;
                if (a_reg == '0)
                begin
                    if (b_reg == '0)
                    begin
                        kind_next  = (c_reg == '0) ? qrs_pkg::KIND_INFINITE
                                                   : qrs_pkg::KIND_NONE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Linear root -c/b
                        kind_next          = qrs_pkg::KIND_LINEAR;
                        neg_next           = (c_reg != '0) && (c_reg[W-1] == b_reg[W-1]);
                        step_ctl.start     = 1'b1;
                        step_ctl.sqrt_mode = 1'b0;
                        step_opnd          = OW'({mag_c, {qrs_pkg::OUT_FRAC{1'b0}}})
                                             << (OW - NW);
                        step_den           = {1'b0, mag_b};
                        step_cnt           = CNTW'(NW);
                        state_next         = S_DIVP;
                    end
                end
                else
                begin
                    disc_next  = DSW'(mul_p);
                    state_next = S_MULAC;
                end
            end
            S_MULAC:
            begin
                prod_next  = mul_p;
                state_next = S_DISC;
            end
            S_DISC:
            begin
                if (a_reg[W-1] != c_reg[W-1])
                begin
                    disc_next = disc_reg + $signed(prod4);
                end
                else
                begin
                    disc_next = disc_reg - $signed(prod4);
                end
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                if (disc_reg[DSW-1])
                begin
                    kind_next  = qrs_pkg::KIND_NO_REAL;
                    state_next = S_DONE;
                end
                else
                begin
                    kind_next          = (disc_reg == '0) ? qrs_pkg::KIND_DOUBLE
                                                          : qrs_pkg::KIND_TWO;
                    step_ctl.start     = 1'b1;
                    step_ctl.sqrt_mode = 1'b1;
                    step_opnd          = OW'(disc_reg[2*W+1:0]) << (OW - (2 * W + 2));
                    step_cnt           = CNTW'(W + 1);
                    state_next         = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (step_done)
                begin
                    sq_next    = step_acc[W:0];
                    state_next = S_DIVP_GO;
                end
            end
            S_DIVP_GO, S_DIVM_GO:
            begin
                neg_next           = num_sel[RNW-1] != a_reg[W-1];
                step_ctl.start     = 1'b1;
                step_ctl.sqrt_mode = 1'b0;
                step_opnd          = OW'({num_mag[RNW-2:0], {qrs_pkg::OUT_FRAC{1'b0}}})
                                     << (OW - NW);
                step_den           = {mag_a, 1'b0};
                step_cnt           = CNTW'(NW);
                state_next         = (state_reg == S_DIVP_GO) ? S_DIVP : S_DIVM;
            end
            S_DIVP:
            begin
                if (step_done)
                begin
                    rp_next    = q_val;
                    sat_next   = sat_reg | q_sat;
                    state_next = (kind_reg == qrs_pkg::KIND_TWO) ? S_DIVM_GO : S_DONE;
                end
            end
            S_DIVM:
            begin
                if (step_done)
                begin
                    rm_next    = q_val;
                    sat_next   = sat_reg | q_sat;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_kind_next  = kind_reg;
                    out_rp_next    = rp_reg;
                    out_rm_next    = rm_reg;
                    out_sat_next   = sat_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        disc_reg     <= disc_next;
        prod_reg     <= prod_next;
        sq_reg       <= sq_next;
        kind_reg     <= kind_next;
        rp_reg       <= rp_next;
        rm_reg       <= rm_next;
        sat_reg      <= sat_next;
        neg_reg      <= neg_next;
        out_kind_reg <= out_kind_next;
        out_rp_reg   <= out_rp_next;
        out_rm_reg   <= out_rm_next;
        out_sat_reg  <= out_sat_next;
    end

    qrs_step_unit #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (step_ctl),
        .opnd_in (step_opnd),
        .den_in  (step_den),
        .steps   (step_cnt),
        .done    (step_done),
        .acc     (step_acc)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign solution_kind  = out_kind_reg;
    assign root_plus      = out_rp_reg;
    assign root_minus     = out_rm_reg;
    assign root_saturated = out_sat_reg;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CW            = 16;
    localparam int DIRECTED_N    = 23;
    localparam int RANDOM_ITEMS  = 226;   // per idling phase, three phases
    localparam int LONG_HOLD     = 600;
    localparam int DRAIN_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_GAP       = 24;
    localparam int ERR_PRINT_MAX = 50;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] rp;
        logic [31:0] rm;
        logic        sat;
    } roots_t;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        logic                 typed;
        roots_t               want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;
    logic                 out_valid;
    logic                 out_ready;
    logic [2:0]           solution_kind;
    logic signed [31:0]   root_plus;
    logic signed [31:0]   root_minus;
    logic                 root_saturated;

    roots_t expected_roots[$];
    row_t   directed_rows [DIRECTED_N];
    int     error_count;
    int     kinds_seen [6];
    int     saturated_seen;
    int     items_sent;
    int     send_idle_pct;
    int     recv_idle_pct;
    logic   hold_req;
    logic   stall_out;

    quadratic_root_solver_core #(
        .COEF_WIDTH(CW)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coef_a        (coef_a),
        .coef_b        (coef_b),
        .coef_c        (coef_c),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .solution_kind (solution_kind),
        .root_plus     (root_plus),
        .root_minus    (root_minus),
        .root_saturated(root_saturated)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Floor square root, two bits of the operand per step
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned acc;
        longint unsigned probe;
        acc   = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= acc + probe)
            begin
                v   = v - (acc + probe);
                acc = (acc >> 1) + probe;
            end
            else
                acc = acc >> 1;
            probe = probe >> 2;
        end
        return acc;
    endfunction

    // Truncate toward zero and clip to int32; the top bit flags clipping
    function automatic logic [32:0] clip_quotient(input logic neg,
                                                  input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned quo;
        longint unsigned neg_quo;
        quo = num / den;
        if (!neg)
        begin
            if (quo > 64'h7FFF_FFFF)
                return {1'b1, 32'h7FFF_FFFF};
            return {1'b0, quo[31:0]};
        end
        if (quo > 64'h8000_0000)
            return {1'b1, 32'h8000_0000};
        neg_quo = -quo;
        return {1'b0, neg_quo[31:0]};
    endfunction

    function automatic logic [32:0] root_quotient(input longint num, input longint a);
        return clip_quotient((num < 0) != (a < 0), magnitude(num) << qrs_pkg::OUT_FRAC,
                             magnitude(a) << 1);
    endfunction

    // Expected result for one equation
    function automatic roots_t predict_roots(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b,
                                             input logic signed [CW-1:0] c);
        longint          sa, sb, sc, sq;
        longint unsigned bb, prod, quarter, disc_q, s, t;
        logic            has_roots, up;
        logic [32:0]     qp, qm;
        roots_t          res;
        sa  = longint'(a);
        sb  = longint'(b);
        sc  = longint'(c);
        res = '0;
        if (sa == 0)
        begin
            if (sb == 0)
                res.kind = (sc == 0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
            else
            begin
                res.kind = qrs_pkg::KIND_LINEAR;
                qp = clip_quotient(((sc > 0) != (sb < 0)) && (sc != 0),
                                   magnitude(sc) << qrs_pkg::OUT_FRAC, magnitude(sb));
                res.rp  = qp[31:0];
                res.sat = qp[32];
            end
        end
        else
        begin
            // D = 4*disc_q + (b*b mod 4), the remainder being 0 or 1
            bb        = magnitude(sb) * magnitude(sb);
            prod      = magnitude(sa) * magnitude(sc);
            quarter   = bb >> 2;
            has_roots = 1'b1;
            disc_q    = 0;
            if ((sa < 0) != (sc < 0))
                disc_q = quarter + prod;
            else if (quarter < prod)
                has_roots = 1'b0;
            else
                disc_q = quarter - prod;

            if (!has_roots)
                res.kind = qrs_pkg::KIND_NO_REAL;
            else
            begin
                s  = floor_sqrt(disc_q);
                t  = s * s + s;
                up = bb[0] ? (t <= disc_q) : (t < disc_q);
                sq = longint'(2 * s + (up ? 1 : 0));
                if (disc_q == 0 && bb[0] == 1'b0)
                begin
                    res.kind = qrs_pkg::KIND_DOUBLE;
                    qp       = root_quotient(-sb, sa);
                    res.rp   = qp[31:0];
                    res.sat  = qp[32];
                end
                else
                begin
                    res.kind = qrs_pkg::KIND_TWO;
                    qp       = root_quotient(-sb + sq, sa);
                    qm       = root_quotient(-sb - sq, sa);
                    res.rp   = qp[31:0];
                    res.rm   = qm[31:0];
                    res.sat  = qp[32] | qm[32];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < ERR_PRINT_MAX)
            $display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Draw one equation, weighted toward the interesting regions
    task automatic pick_equation(output logic signed [CW-1:0] a,
                                 output logic signed [CW-1:0] b,
                                 output logic signed [CW-1:0] c);
        int sel, x, y, lim, s, sg;
        int pool [6];
        pool = '{-32768, -32767, -1, 0, 1, 32767};
        sel  = $urandom_range(99);
        a    = CW'($urandom);
        b    = CW'($urandom);
        c    = CW'($urandom);
        if (sel >= 30 && sel < 45)
        begin
            // linear equation, occasionally with a zero constant
            a = '0;
            if ($urandom_range(7) == 0)
                c = '0;
        end
        else if (sel >= 45 && sel < 50)
        begin
            // degenerate: no unknown left
            a = '0;
            b = '0;
            if ($urandom_range(1) == 0)
                c = '0;
        end
        else if (sel >= 50 && sel < 65)
        begin
            // double root: a = g*s*x^2, c = g*s*y^2 with one sign g, b = +/-2*s*x*y
            x   = $urandom_range(1, 15);
            y   = $urandom_range(0, 15);
            lim = x * x;
            if (y * y > lim)
                lim = y * y;
            if (2 * x * y > lim)
                lim = 2 * x * y;
            s  = $urandom_range(1, 32767 / lim);
            sg = ($urandom_range(1) == 0) ? 1 : -1;
            a  = CW'(sg * s * x * x);
            c  = CW'(sg * s * y * y);
            b  = CW'((($urandom_range(1) == 0) ? 1 : -1) * 2 * s * x * y);
        end
        else if (sel >= 65 && sel < 80)
        begin
            a = CW'($urandom_range(32) - 16);
            b = CW'($urandom_range(32) - 16);
            c = CW'($urandom_range(32) - 16);
        end
        else if (sel >= 80 && sel < 90)
        begin
            a = CW'(pool[$urandom_range(5)]);
            b = CW'(pool[$urandom_range(5)]);
            c = CW'(pool[$urandom_range(5)]);
        end
        else if (sel >= 90)
        begin
            // tiny leading term drives the roots into saturation
            a = CW'(($urandom_range(1) == 0) ? $urandom_range(1, 4)
                                             : -$urandom_range(1, 4));
        end
    endtask

    // Offer one item after a random gap and log its expectation at accept
    task automatic send_equation(input logic signed [CW-1:0] a,
                                 input logic signed [CW-1:0] b,
                                 input logic signed [CW-1:0] c,
                                 input logic typed,
                                 input roots_t want);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        coef_a   <= a;
        coef_b   <= b;
        coef_c   <= c;
        do
            @(posedge clk);
        while (!in_ready);
        expected_roots.push_back(typed ? want : predict_roots(a, b, c));
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        roots_t want;
        if (expected_roots.size() == 0)
        begin
            report_mismatch("result item with none pending, kind", solution_kind, 0);
            return;
        end
        want = expected_roots.pop_front();
        if (solution_kind !== want.kind)
            report_mismatch("solution_kind", solution_kind, want.kind);
        if (root_plus !== want.rp)
            report_mismatch("root_plus", root_plus, want.rp);
        if (root_minus !== want.rm)
            report_mismatch("root_minus", root_minus, want.rm);
        if (root_saturated !== want.sat)
            report_mismatch("root_saturated", root_saturated, want.sat);
        if (want.kind <= qrs_pkg::KIND_NONE)
            kinds_seen[want.kind]++;
        if (want.sat)
            saturated_seen++;
    endtask

    // Accept results and randomize ready for the next cycle
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result();
            out_ready <= !stall_out && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold the output side off for a long stretch once requested
    initial
    begin
        stall_out = 1'b0;
        wait (hold_req);
        stall_out <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        stall_out <= 1'b0;
    end

    // Abort a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Run stopped after %0d cycles with %0d results pending",
                 CYCLE_LIMIT, expected_roots.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main stimulus
    initial
    begin
        int                   sender_pct [3];
        int                   receiver_pct [3];
        logic signed [CW-1:0] ra, rb, rc;
        sender_pct     = '{34, 64, 0};
        receiver_pct   = '{64, 34, 0};
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        coef_a         = '0;
        coef_b         = '0;
        coef_c         = '0;
        hold_req       = 1'b0;
        error_count    = 0;
        saturated_seen = 0;
        items_sent     = 0;
        kinds_seen     = '{0, 0, 0, 0, 0, 0};
        send_idle_pct  = sender_pct[0];
        recv_idle_pct  = receiver_pct[0];

        // a, b, c, typed, {kind, root_plus, root_minus, saturated}
        directed_rows = '{
            '{16'sd0, 16'sd0, 16'sd0, 1'b1,
              '{qrs_pkg::KIND_INFINITE, 32'h0, 32'h0, 1'b0}},
            '{16'sd0, 16'sd0, 16'sd5, 1'b1, '{qrs_pkg::KIND_NONE, 32'h0, 32'h0, 1'b0}},
            '{16'sd0, 16'sd0, 16'sh8000, 1'b1,
              '{qrs_pkg::KIND_NONE, 32'h0, 32'h0, 1'b0}},
            '{16'sd1, 16'sd0, 16'sd1, 1'b1,
              '{qrs_pkg::KIND_NO_REAL, 32'h0, 32'h0, 1'b0}},
            '{16'sd1, 16'sd2, 16'sd1, 1'b1,
              '{qrs_pkg::KIND_DOUBLE, 32'hFFFF_0000, 32'h0, 1'b0}},
            '{16'sd1, 16'sd0, -16'sd1, 1'b1,
              '{qrs_pkg::KIND_TWO, 32'h0001_0000, 32'hFFFF_0000, 1'b0}},
            '{16'sd0, 16'sd1, 16'sh8000, 1'b1,
              '{qrs_pkg::KIND_LINEAR, 32'h7FFF_FFFF, 32'h0, 1'b1}},
            '{16'sd0, -16'sd1, 16'sh8000, 1'b1,
              '{qrs_pkg::KIND_LINEAR, 32'h8000_0000, 32'h0, 1'b0}},
            '{16'sd0, 16'sd1, 16'sd32767, 1'b1,
              '{qrs_pkg::KIND_LINEAR, 32'h8001_0000, 32'h0, 1'b0}},
            '{16'sd0, 16'sd256, 16'sd512, 1'b1,
              '{qrs_pkg::KIND_LINEAR, 32'hFFFE_0000, 32'h0, 1'b0}},
            '{-16'sd1, 16'sd0, 16'sd0, 1'b1,
              '{qrs_pkg::KIND_DOUBLE, 32'h0, 32'h0, 1'b0}},
            '{16'sd0, 16'sh8000, 16'sd1, 1'b0, '0},
            '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
            '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
            '{16'sh8000, 16'sd0, 16'sd32767, 1'b0, '0},
            '{16'sd1, 16'sh8000, 16'sd0, 1'b0, '0},
            '{-16'sd1, 16'sd32767, 16'sh8000, 1'b0, '0},
            '{16'sd32767, 16'sh8000, 16'sh8000, 1'b0, '0},
            '{16'sd1, 16'sd1, 16'sd0, 1'b0, '0},
            '{16'sd2, -16'sd3, 16'sd1, 1'b0, '0},
            '{16'sh8000, 16'sd32767, 16'sd0, 1'b0, '0},
            '{16'sd32767, 16'sd0, 16'sh8000, 1'b0, '0},
            '{16'sd1, 16'sh8000, 16'sh8000, 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
            send_equation(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                          directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // Random items under three idling mixes; long output hold in the last
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = sender_pct[phase];
            recv_idle_pct = receiver_pct[phase];
            if (phase == 2)
                hold_req = 1'b1;
            repeat (RANDOM_ITEMS)
            begin
                pick_equation(ra, rb, rc);
                send_equation(ra, rb, rc, 1'b0, '0);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_roots.size() != 0)
            report_mismatch("results never delivered, count", expected_roots.size(), 0);

        $display("Solved %0d equations: two %0d, double %0d, no real %0d, linear %0d, ",
                 items_sent, kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
        $display("  infinite %0d, none %0d, clipped %0d; idle mixes and a %0d-cycle hold",
                 kinds_seen[4], kinds_seen[5], saturated_seen, LONG_HOLD);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
